>>> rtl/core/obpa_pkg.sv
// Shared types, codes and default sizes of the owned block pool allocator.
package obpa_pkg;

   localparam int NUM_BLOCKS_DEF  = 32;
   localparam int BLOCK_BYTES_DEF = 128;
   localparam int NUM_PROCS_DEF   = 8;
   localparam int WAIT_LEVELS_DEF = 4;

   localparam int ADDR_W   = 32;
   localparam int CMD_W    = 2;
   localparam int PID_W    = 3;
   localparam int PRIO_W   = 3;
   localparam int STATUS_W = 3;

   localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC_WAIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_REASSIGN   = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ALIGN   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OWNER   = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_BLOCKED = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] blk_address;
      logic [PID_W-1:0]  caller_pid;
      logic [PRIO_W-1:0] caller_prio;
      logic [PID_W-1:0]  new_owner_pid;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   grant_address;
      logic                woken_valid;
      logic [PID_W-1:0]    woken_pid;
      logic                preempt;
   } rsp_type;

endpackage

>>> rtl/core/owned_block_pool_allocator_top.sv
// Top level of the owned block pool allocator: free list, owner tags and priority wait queues.
//
// The pool hands out fixed-size blocks from a FIFO free list, tags each block with its owner,
// parks blocking requesters in one FIFO per priority level and passes released blocks to the
// oldest waiter of the most urgent level. After reset the block runs a clearing pass over
// every entry of the owner table and free list, during which req_ready stays low;
// heap_base may be written at any time the block is idle. A request (cmd 0 or 1) first
// reads the free list head from its memory, then checks and writes back. A release or
// reassign of an address inside the heap passes through a divide step (S_DIV), in which the
// block index is recovered from the address offset by a multiplication with the reciprocal
// of BLOCK_BYTES and the owner table is read; an address outside the heap skips that step.
// A finished result sits in an output register, so the next beat is accepted while it waits.
module owned_block_pool_allocator_top #(
   parameter int NUM_BLOCKS  = obpa_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = obpa_pkg::BLOCK_BYTES_DEF,
   parameter int NUM_PROCS   = obpa_pkg::NUM_PROCS_DEF,
   parameter int WAIT_LEVELS = obpa_pkg::WAIT_LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  obpa_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output obpa_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [obpa_pkg::ADDR_W-1:0]     csr_wdata
);

   localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
   localparam int SPAN    = NUM_BLOCKS * BLOCK_BYTES;
   localparam int OFF_W   = $clog2(SPAN + 1);
   localparam int RECIP_S = OFF_W + $clog2(BLOCK_BYTES);
   localparam int RM_W    = OFF_W + 2;
   localparam int PROD_W  = OFF_W + RM_W;
   localparam longint unsigned RECIP_M =
      ((64'd1 << RECIP_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
   localparam logic [RM_W-1:0] RECIP_K = RM_W'(RECIP_M);
   localparam int WH_W    = $clog2(NUM_PROCS);
   localparam int WCNT_W  = $clog2(NUM_PROCS + 1);
   localparam int WSUM_W  = WCNT_W + 1;
   localparam int FSUM_W  = CNT_W + 1;
   localparam int LVL_W   = (WAIT_LEVELS > 1) ? $clog2(WAIT_LEVELS) : 1;
   localparam int WDEPTH  = WAIT_LEVELS * NUM_PROCS;
   localparam int WADDR_W = $clog2(WDEPTH);
   localparam int PID_W   = obpa_pkg::PID_W;
   localparam int OWN_W   = PID_W + 1;
   localparam int ADDR_W  = obpa_pkg::ADDR_W;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   obpa_pkg::req_type     cur_ff, cur_in;
   logic                  range_ok_ff, range_ok_in;
   logic [OFF_W-1:0]      rem_ff, rem_in;
   logic [IDX_W-1:0]      quo_ff, quo_in;
   logic [IDX_W-1:0]      init_ptr_ff, init_ptr_in;
   logic [IDX_W-1:0]      free_head_ff, free_head_in;
   logic [CNT_W-1:0]      free_count_ff, free_count_in;
   logic [WH_W-1:0]       wait_head_ff [WAIT_LEVELS];
   logic [WH_W-1:0]       wait_head_in [WAIT_LEVELS];
   logic [WCNT_W-1:0]     wait_count_ff [WAIT_LEVELS];
   logic [WCNT_W-1:0]     wait_count_in [WAIT_LEVELS];
   obpa_pkg::rsp_type     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   obpa_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  own_we;
   logic [IDX_W-1:0]      own_waddr;
   logic [OWN_W-1:0]      own_wdata;
   logic [OWN_W-1:0]      own_rdata;
   logic                  free_we;
   logic [IDX_W-1:0]      free_waddr;
   logic [IDX_W-1:0]      free_wdata;
   logic [IDX_W-1:0]      free_rdata;
   logic                  wait_we;
   logic [WADDR_W-1:0]    wait_waddr;
   logic [PID_W-1:0]      wait_wdata;
   logic [WADDR_W-1:0]    wait_raddr;
   logic [PID_W-1:0]      wait_rdata;

   logic                  any_wait;
   logic [LVL_W-1:0]      first_lvl;
   logic                  wait_over;
   logic                  accept;
   logic [ADDR_W:0]       addr_ext;
   logic [ADDR_W:0]       base_ext;
   logic [ADDR_W:0]       end_ext;
   logic [ADDR_W-1:0]     off_full;
   logic [PROD_W-1:0]     recip_prod;
   logic [IDX_W-1:0]      quo_calc;
   logic [OFF_W-1:0]      blk_off;
   logic                  out_free;
   logic [LVL_W-1:0]      prio_lvl;
   logic [WSUM_W-1:0]     wslot_sum;
   logic [WH_W-1:0]       wslot;
   logic [FSUM_W-1:0]     ftail_sum;
   logic [IDX_W-1:0]      ftail;
   obpa_pkg::rsp_type     res;
   logic                  finish;

   obpa_ram #(.WIDTH(OWN_W), .DEPTH(NUM_BLOCKS)) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_addr (quo_in),
      .rd_data (own_rdata)
   );

   obpa_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BLOCKS)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_we),
      .wr_addr (free_waddr),
      .wr_data (free_wdata),
      .rd_addr (free_head_ff),
      .rd_data (free_rdata)
   );

   obpa_ram #(.WIDTH(PID_W), .DEPTH(WDEPTH)) u_wait_ram (
      .clock   (clock),
      .wr_en   (wait_we),
      .wr_addr (wait_waddr),
      .wr_data (wait_wdata),
      .rd_addr (wait_raddr),
      .rd_data (wait_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      any_wait  = 1'b0;
      first_lvl = '0;
      wait_over = 1'b0;
      for (int l = WAIT_LEVELS - 1; l >= 0; l--) begin
         if (wait_count_ff[l] != '0) begin
            any_wait  = 1'b1;
            first_lvl = LVL_W'(l);
         end
         if (wait_count_ff[l] > WCNT_W'(NUM_PROCS)) begin
            wait_over = 1'b1;
         end
      end
   end

   assign wait_raddr = WADDR_W'(int'(first_lvl) * NUM_PROCS + int'(wait_head_ff[first_lvl]));

   assign addr_ext   = {1'b0, req_data.blk_address};
   assign base_ext   = {1'b0, base_ff};
   assign end_ext    = base_ext + (ADDR_W + 1)'(SPAN);
   assign off_full   = req_data.blk_address - base_ff;
   assign recip_prod = PROD_W'(rem_ff) * PROD_W'(RECIP_K);
   assign quo_calc   = IDX_W'(recip_prod >> RECIP_S);
   assign blk_off    = OFF_W'(quo_ff) * OFF_W'(BLOCK_BYTES);
   assign prio_lvl   = LVL_W'(cur_ff.caller_prio);

   assign wslot_sum = WSUM_W'(wait_head_ff[prio_lvl]) + WSUM_W'(wait_count_ff[prio_lvl]);
   assign wslot     = (wslot_sum >= WSUM_W'(NUM_PROCS)) ?
                      WH_W'(wslot_sum - WSUM_W'(NUM_PROCS)) : WH_W'(wslot_sum);
   assign ftail_sum = FSUM_W'(free_head_ff) + FSUM_W'(free_count_ff);
   assign ftail     = (ftail_sum >= FSUM_W'(NUM_BLOCKS)) ?
                      IDX_W'(ftail_sum - FSUM_W'(NUM_BLOCKS)) : IDX_W'(ftail_sum);

   always_comb begin
      state_in      = state_ff;
      base_in       = csr_we ? csr_wdata : base_ff;
      cur_in        = cur_ff;
      range_ok_in   = range_ok_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      init_ptr_in   = init_ptr_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      wait_head_in  = wait_head_ff;
      wait_count_in = wait_count_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      own_we        = 1'b0;
      own_waddr     = quo_ff;
      own_wdata     = '0;
      free_we       = 1'b0;
      free_waddr    = ftail;
      free_wdata    = quo_ff;
      wait_we       = 1'b0;
      wait_waddr    = WADDR_W'(int'(prio_lvl) * NUM_PROCS + int'(wslot));
      wait_wdata    = cur_ff.caller_pid;
      res           = '0;
      finish        = 1'b0;

      case (state_ff)
         S_INIT: begin
            own_we      = 1'b1;
            own_waddr   = init_ptr_ff;
            own_wdata   = '0;
            free_we     = 1'b1;
            free_waddr  = init_ptr_ff;
            free_wdata  = init_ptr_ff;
            init_ptr_in = init_ptr_ff + IDX_W'(1);
            if (init_ptr_ff == IDX_W'(NUM_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cur_in      = req_data;
               range_ok_in = (addr_ext >= base_ext) && (addr_ext < end_ext);
               rem_in      = OFF_W'(off_full);
               quo_in      = '0;
               if (req_data.cmd == obpa_pkg::CMD_ALLOC ||
                   req_data.cmd == obpa_pkg::CMD_ALLOC_WAIT ||
                   !range_ok_in) begin
                  state_in = S_CHECK;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            quo_in   = quo_calc;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            finish = 1'b1;
            if (cur_ff.cmd == obpa_pkg::CMD_ALLOC || cur_ff.cmd == obpa_pkg::CMD_ALLOC_WAIT) begin
               if (free_count_ff != '0) begin
                  own_we        = 1'b1;
                  own_waddr     = free_rdata;
                  own_wdata     = {1'b1, cur_ff.caller_pid};
                  free_head_in  = (free_head_ff == IDX_W'(NUM_BLOCKS - 1)) ?
                                  '0 : free_head_ff + IDX_W'(1);
                  free_count_in = free_count_ff - CNT_W'(1);
                  res.grant_address = base_ff + 32'(free_rdata) * 32'(BLOCK_BYTES);
               end else if (cur_ff.cmd == obpa_pkg::CMD_ALLOC_WAIT &&
                            32'(cur_ff.caller_prio) < 32'(WAIT_LEVELS) &&
                            wait_count_ff[prio_lvl] < WCNT_W'(NUM_PROCS)) begin
                  wait_we                 = 1'b1;
                  wait_count_in[prio_lvl] = wait_count_ff[prio_lvl] + WCNT_W'(1);
                  res.status              = obpa_pkg::STAT_BLOCKED;
               end else begin
                  res.status = obpa_pkg::STAT_NONE;
               end
            end else if (!range_ok_ff) begin
               res.status = obpa_pkg::STAT_RANGE;
            end else if (rem_ff != blk_off) begin
               res.status = obpa_pkg::STAT_ALIGN;
            end else if (!own_rdata[OWN_W-1] || own_rdata[PID_W-1:0] != cur_ff.caller_pid) begin
               res.status = obpa_pkg::STAT_OWNER;
            end else if (cur_ff.cmd == obpa_pkg::CMD_REASSIGN) begin
               own_we    = 1'b1;
               own_wdata = {1'b1, cur_ff.new_owner_pid};
            end else if (any_wait) begin
               own_we    = 1'b1;
               own_wdata = {1'b1, wait_rdata};
               wait_head_in[first_lvl]  = (wait_head_ff[first_lvl] == WH_W'(NUM_PROCS - 1)) ?
                                          '0 : wait_head_ff[first_lvl] + WH_W'(1);
               wait_count_in[first_lvl] = wait_count_ff[first_lvl] - WCNT_W'(1);
               res.grant_address = cur_ff.blk_address;
               res.woken_valid   = 1'b1;
               res.woken_pid     = wait_rdata;
               res.preempt       = (4'(first_lvl) < 4'(cur_ff.caller_prio));
            end else begin
               own_we    = 1'b1;
               own_wdata = '0;
               if (free_count_ff < CNT_W'(NUM_BLOCKS)) begin
                  free_we       = 1'b1;
                  free_count_in = free_count_ff + CNT_W'(1);
               end
            end
         end
         S_HOLD: begin
            if (rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         if (out_free) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            res_in   = res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         base_ff       <= '0;
         init_ptr_ff   <= '0;
         free_head_ff  <= '0;
         free_count_ff <= CNT_W'(NUM_BLOCKS);
         rsp_valid_ff  <= 1'b0;
         for (int l = 0; l < WAIT_LEVELS; l++) begin
            wait_head_ff[l]  <= '0;
            wait_count_ff[l] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         init_ptr_ff   <= init_ptr_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         wait_head_ff  <= wait_head_in;
         wait_count_ff <= wait_count_in;
      end
      cur_ff      <= cur_in;
      range_ok_ff <= range_ok_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   a_free_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(NUM_BLOCKS))
      else $error("Free list count exceeds the number of blocks.");

   a_wait_count_bound: assert property (@(posedge clock) disable iff (reset)
      !wait_over)
      else $error("A wait queue holds more entries than processes.");

   a_woken_means_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.woken_valid |-> rsp_data.status == obpa_pkg::STAT_OK)
      else $error("A woken waiter is reported with an error status.");

   a_hold_keeps_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("A result is held back while the output register is empty.");

endmodule

>>> rtl/core/obpa_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module obpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
